/* sv/iwcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwcs_pkg
// Shared types and constants for the Wolff cluster step block.
// ----------------------------------------------------------------------------
package iwcs_pkg;

	// Grid geometry (SIDE must be a power of two)
	localparam int SIDE        = 64;
	localparam int XW          = $clog2(SIDE);
	localparam int NSITES      = SIDE * SIDE;
	localparam int SA_W        = $clog2(NSITES);
	localparam int STACK_DEPTH = 2 * NSITES;
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int SP_W        = STK_AW + 1;
	localparam int IDX_W       = SA_W + 1;

	// Payload widths
	localparam int OP_W    = 2;
	localparam int SITE_W  = 12;
	localparam int CNT_W   = 13;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 1;

	// Random generator
	localparam logic [15:0] SEED_DEFAULT = 16'd44257;
	localparam logic [15:0] LFSR_TAPS    = 16'hB400;

	// Mark bits
	localparam int MARK_W    = 3;
	localparam int MARK_FLIP = 0;
	localparam int MARK_XB   = 1;
	localparam int MARK_YB   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_STEP  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_THRESHOLD = 1'b0,
		CFG_SEED      = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_POP,
		ST_SITE,
		ST_SITE_WAIT,
		ST_BOND_RD,
		ST_BOND_EV,
		ST_SITE_WB,
		ST_FLIP,
		ST_DONE
	} state_t;

	// One Galois LFSR draw
	function automatic logic [15:0] lfsr_next(input logic [15:0] r);
		logic [15:0] n;
		n = {1'b0, r[15:1]};
		if (r[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

endpackage

/* sv/ising_wolff_cluster_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_wolff_cluster_step
// Toroidal Ising spin grid with Wolff cluster update, spin read and write.
// ----------------------------------------------------------------------------
// After reset the block sweeps the spin and mark memories to zero, one site
// per cycle, and takes no transaction until done. A read passes through a
// read state before its result is loaded; write and ignored commands load
// the result directly. A cluster step handles each site popped off the stack
// in order: pop, stack read, a spin/mark read of the site, a read and an
// evaluate step for each of the four bonds over the one read port of the mark
// and spin memories, then the mark write-back of the site. It ends with one
// final pop of the empty stack, a flip pass that inverts marked sites and
// clears all marks for the next step, and a state to load the result. A site
// can be pushed once per accepted bond, so up to 2*NSITES + 1 pops may occur.
// A finished result waits in an output register.
// ----------------------------------------------------------------------------
module ising_wolff_cluster_step import iwcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   operation,
	input  logic [SITE_W-1:0] site_index,
	input  logic              spin_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              spin_out,
	output logic [CNT_W-1:0]  flipped_count,
	input  logic              cfg_wr_en,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_wr_data
);

	// Memories
	logic              spin_mem [NSITES];
	logic [MARK_W-1:0] mark_mem [NSITES];
	logic [SA_W-1:0]   stack_mem [STACK_DEPTH];

	logic              spin_we, spin_wdata, spin_rdata;
	logic [SA_W-1:0]   spin_waddr, spin_raddr;
	logic              mark_we;
	logic [MARK_W-1:0] mark_wdata, mark_rdata;
	logic [SA_W-1:0]   mark_waddr, mark_raddr;
	logic              stk_we;
	logic [SA_W-1:0]   stk_wdata, stk_rdata;
	logic [STK_AW-1:0] stk_waddr, stk_raddr;

	// Control and datapath registers
	state_t            state_q, state_d;
	logic [IDX_W-1:0]  idx_q;
	logic [SP_W-1:0]   sp_q;
	logic [15:0]       thr_q, lfsr_q;
	logic [SA_W-1:0]   s_q;
	logic              s_spin_q;
	logic [MARK_W-1:0] s_mark_q;
	logic [1:0]        bond_q;
	logic              flip_vld_s1;
	logic [SA_W-1:0]   flip_addr_s1;
	logic [CNT_W-1:0]  cnt_q;

	// Output register
	logic              res_load, res_spin;
	logic [CNT_W-1:0]  res_cnt;

	logic in_fire, site_ok;
	assign in_fire = in_valid && in_ready;
	assign site_ok = (32'(site_index) < NSITES);

	// Neighbor of the current site for the active bond: x+1, x-1, y+1, y-1
	logic [XW-1:0]   sx, sy, nx, ny;
	logic [SA_W-1:0] nb_addr;
	logic            owner_is_nb;
	logic [MARK_W-1:0] bond_bit;
	always_comb begin
		sx = s_q[XW-1:0];
		sy = s_q[SA_W-1:XW];
		nx = sx;
		ny = sy;
		case (bond_q)
			2'd0: nx = (32'(sx) == SIDE - 1) ? '0 : sx + 1'b1;
			2'd1: nx = (sx == '0) ? XW'(SIDE - 1) : sx - 1'b1;
			2'd2: ny = (32'(sy) == SIDE - 1) ? '0 : sy + 1'b1;
			default: ny = (sy == '0) ? XW'(SIDE - 1) : sy - 1'b1;
		endcase
		nb_addr     = {ny, nx};
		owner_is_nb = bond_q[0];
		bond_bit    = '0;
		bond_bit[bond_q[1] ? MARK_YB : MARK_XB] = 1'b1;
	end

	// Bond evaluation
	logic [15:0]       draw;
	logic              tried, accept;
	logic [MARK_W-1:0] nb_mark_new, s_mark_new;
	always_comb begin
		draw   = lfsr_next(lfsr_q);
		tried  = owner_is_nb ? |(mark_rdata & bond_bit) : |(s_mark_q & bond_bit);
		accept = !tried && (spin_rdata == s_spin_q) && (draw < thr_q);
		nb_mark_new = mark_rdata;
		s_mark_new  = s_mark_q;
		if (owner_is_nb) begin
			nb_mark_new = nb_mark_new | bond_bit;
		end else begin
			s_mark_new = s_mark_new | bond_bit;
		end
		if (accept) begin
			nb_mark_new[MARK_FLIP] = 1'b1;
			s_mark_new[MARK_FLIP]  = 1'b1;
		end
	end

	// Next state and memory port control
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		spin_we    = 1'b0;
		spin_waddr = site_index[SA_W-1:0];
		spin_wdata = spin_in;
		spin_raddr = site_index[SA_W-1:0];
		mark_we    = 1'b0;
		mark_waddr = site_index[SA_W-1:0];
		mark_wdata = '0;
		mark_raddr = nb_addr;
		stk_we     = 1'b0;
		stk_waddr  = sp_q[STK_AW-1:0];
		stk_wdata  = nb_addr;
		stk_raddr  = STK_AW'(sp_q - 1'b1);
		res_load   = 1'b0;
		res_spin   = 1'b0;
		res_cnt    = '0;
		case (state_q)
			ST_CLEAR: begin
				spin_we    = 1'b1;
				spin_waddr = idx_q[SA_W-1:0];
				spin_wdata = 1'b0;
				mark_we    = 1'b1;
				mark_waddr = idx_q[SA_W-1:0];
				if (32'(idx_q) == NSITES - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = !out_valid || out_ready;
				if (in_fire) begin
					if (site_ok && operation == OP_STEP) begin
						// seed goes on the stack, marked for flipping
						mark_we    = 1'b1;
						mark_wdata = MARK_W'(1) << MARK_FLIP;
						stk_we     = 1'b1;
						stk_waddr  = '0;
						stk_wdata  = site_index[SA_W-1:0];
						state_d    = ST_POP;
					end else if (site_ok && operation == OP_READ) begin
						state_d = ST_READ;
					end else begin
						spin_we  = site_ok && operation == OP_WRITE;
						res_load = 1'b1;
					end
				end
			end
			ST_READ: begin
				res_load = 1'b1;
				res_spin = spin_rdata;
				state_d  = ST_IDLE;
			end
			ST_POP: begin
				state_d = (sp_q == '0) ? ST_FLIP : ST_SITE;
			end
			ST_SITE: begin
				spin_raddr = stk_rdata;
				mark_raddr = stk_rdata;
				state_d    = ST_SITE_WAIT;
			end
			ST_SITE_WAIT: begin
				state_d = ST_BOND_RD;
			end
			ST_BOND_RD: begin
				spin_raddr = nb_addr;
				mark_raddr = nb_addr;
				state_d    = ST_BOND_EV;
			end
			ST_BOND_EV: begin
				mark_we    = 1'b1;
				mark_waddr = nb_addr;
				mark_wdata = nb_mark_new;
				stk_we     = accept && (32'(sp_q) < STACK_DEPTH);
				state_d    = (bond_q == 2'd3) ? ST_SITE_WB : ST_BOND_RD;
			end
			ST_SITE_WB: begin
				mark_we    = 1'b1;
				mark_waddr = s_q;
				mark_wdata = s_mark_q;
				state_d    = ST_POP;
			end
			ST_FLIP: begin
				// read site idx, invert and clear the one read last cycle
				spin_raddr = idx_q[SA_W-1:0];
				mark_raddr = idx_q[SA_W-1:0];
				spin_we    = flip_vld_s1;
				spin_waddr = flip_addr_s1;
				spin_wdata = spin_rdata ^ mark_rdata[MARK_FLIP];
				mark_we    = flip_vld_s1;
				mark_waddr = flip_addr_s1;
				if (32'(idx_q) == NSITES && flip_vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				res_load = 1'b1;
				res_cnt  = cnt_q;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			sp_q        <= '0;
			flip_vld_s1 <= 1'b0;
			bond_q      <= '0;
			thr_q       <= '0;
			lfsr_q      <= SEED_DEFAULT;
			out_valid   <= 1'b0;
		end else begin
			state_q <= state_d;

			// configuration writes
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_THRESHOLD: thr_q <= cfg_wr_data;
					CFG_SEED: lfsr_q <= (cfg_wr_data == '0) ? SEED_DEFAULT : cfg_wr_data;
					default: ;
				endcase
			end else if (state_q == ST_BOND_EV && !tried) begin
				lfsr_q <= draw;
			end

			// sweep index for the clearing and flip passes
			if (state_q == ST_CLEAR) begin
				idx_q <= (32'(idx_q) == NSITES - 1) ? '0 : idx_q + 1'b1;
			end else if (state_q == ST_FLIP) begin
				if (32'(idx_q) < NSITES) begin
					idx_q <= idx_q + 1'b1;
				end
			end else begin
				idx_q <= '0;
			end
			flip_vld_s1 <= (state_q == ST_FLIP) && (32'(idx_q) < NSITES);

			// stack pointer
			if (state_q == ST_IDLE && state_d == ST_POP) begin
				sp_q <= SP_W'(1);
			end else if (state_q == ST_POP && sp_q != '0) begin
				sp_q <= sp_q - 1'b1;
			end else if (stk_we && state_q == ST_BOND_EV) begin
				sp_q <= sp_q + 1'b1;
			end

			// bond counter
			if (state_q == ST_SITE_WAIT) begin
				bond_q <= '0;
			end else if (state_q == ST_BOND_EV) begin
				bond_q <= bond_q + 1'b1;
			end

			// output register
			if (res_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		flip_addr_s1 <= idx_q[SA_W-1:0];
		if (state_q == ST_SITE) begin
			s_q <= stk_rdata;
		end
		if (state_q == ST_SITE_WAIT) begin
			s_spin_q <= spin_rdata;
			s_mark_q <= mark_rdata;
		end else if (state_q == ST_BOND_EV) begin
			s_mark_q <= s_mark_new;
		end
		// flipped site count, saturating
		if (state_q == ST_IDLE) begin
			cnt_q <= '0;
		end else if (state_q == ST_FLIP && flip_vld_s1 && mark_rdata[MARK_FLIP]
				&& cnt_q != '1) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (res_load) begin
			spin_out      <= res_spin;
			flipped_count <= res_cnt;
		end
	end

	// Spin memory
	always_ff @(posedge clk) begin
		if (spin_we) begin
			spin_mem[spin_waddr] <= spin_wdata;
		end
		spin_rdata <= spin_mem[spin_raddr];
	end

	// Mark memory
	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_waddr] <= mark_wdata;
		end
		mark_rdata <= mark_mem[mark_raddr];
	end

	// Site stack
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		stk_rdata <= stack_mem[stk_raddr];
	end

endmodule
